FILE: rtl/assert_macros.svh
// Assertion helpers shared by checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define SIC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define SIC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/sic_pkg.sv
`timescale 1ns / 1ps

package sic_pkg;

    localparam int SET_CAPACITY = 256;
    localparam int LANES        = (SET_CAPACITY < 32) ? SET_CAPACITY : 32;
    localparam int ROWS         = SET_CAPACITY / LANES;
    localparam int LANE_W       = $clog2(LANES);
    localparam int ROW_W        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int RC_W         = ROW_W + 1;
    localparam int IDX_W        = $clog2(SET_CAPACITY);
    localparam int CNT_W        = $clog2(SET_CAPACITY + 1);
    localparam int ID_W         = 32;
    localparam int COUNT_W      = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_FINISH = 2'd2
    } t_action;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

endpackage

FILE: rtl/sic_ram.sv
`timescale 1ns / 1ps

module sic_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

FILE: rtl/set_intersection_counter_unit.sv
// Add/query requests keep the block busy while the stored entries are scanned. The scan reads
// one row of the 32 banked entry RAMs per cycle and compares all 32 lanes. A finish request
// loads the result into an output register, where it sits until taken.
// A finish is held off while a scan runs or while an earlier result is still stalled.
// Reset (i_rst_n low, synchronous) clears count and flags; entry RAM (ids and match marks)
// holds garbage, every entry is written with a clear mark before it is read.
`timescale 1ns / 1ps

module set_intersection_counter_unit
    import sic_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [ID_W-1:0]    i_element_id,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [COUNT_W-1:0] o_common_count,
    output logic               o_overflow
);

    t_state                r_state, n_state;
    logic [ID_W-1:0]       r_id, n_id;
    logic                  r_is_query, n_is_query;
    logic [RC_W-1:0]       r_rows, n_rows;
    logic [RC_W-1:0]       r_rd_row, n_rd_row;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [ROW_W-1:0]      r_cmp_row, n_cmp_row;
    logic                  r_found, n_found;
    logic                  r_hit_mark, n_hit_mark;
    logic [IDX_W-1:0]      r_hit_idx, n_hit_idx;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [COUNT_W-1:0]    r_matches, n_matches;
    logic                  r_ovf, n_ovf;
    logic                  r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]    r_out_count, n_out_count;
    logic                  r_out_ovf, n_out_ovf;

    logic                  accept_in;
    logic                  rd_issue;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [ID_W:0]         wr_data;
    logic [LANES-1:0]      lane_hit;
    logic [LANE_W-1:0]     hit_lane;
    logic                  hit_mark;
    logic [CNT_W:0]        rows_sum;
    logic [ID_W:0]         rdata [LANES];

    assign o_in_stall = (r_state != S_IDLE)
                     || (r_out_valid && i_out_stall && (i_action == ACT_FINISH));
    assign accept_in  = i_in_valid && !o_in_stall;
    assign rd_issue   = (r_state == S_SCAN) && (r_rd_row < r_rows);
    assign rows_sum   = {1'b0, r_count} + (CNT_W + 1)'(LANES - 1);

    // Entry k lives in bank k mod LANES, row k / LANES; top bit is the match mark.
    for (genvar g = 0; g < LANES; g++) begin : g_bank
        sic_ram #(
            .WIDTH (ID_W + 1),
            .DEPTH (ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (wr_en && (wr_idx[LANE_W-1:0] == LANE_W'(g))),
            .i_waddr (ROW_W'(wr_idx >> LANE_W)),
            .i_wdata (wr_data),
            .i_re    (rd_issue),
            .i_raddr (r_rd_row[ROW_W-1:0]),
            .o_rdata (rdata[g])
        );
    end

    always_comb begin
        hit_lane = '0;
        hit_mark = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            lane_hit[l] = r_cmp_vld && (rdata[l][ID_W-1:0] == r_id)
                       && (CNT_W'({r_cmp_row, LANE_W'(l)}) < r_count);
            // stored entries are distinct, so at most one lane hits
            if (lane_hit[l]) begin
                hit_lane = hit_lane | LANE_W'(l);
                hit_mark = hit_mark | rdata[l][ID_W];
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_id        = r_id;
        n_is_query  = r_is_query;
        n_rows      = r_rows;
        n_rd_row    = r_rd_row;
        n_cmp_vld   = 1'b0;
        n_cmp_row   = r_cmp_row;
        n_found     = r_found;
        n_hit_mark  = r_hit_mark;
        n_hit_idx   = r_hit_idx;
        n_count     = r_count;
        n_matches   = r_matches;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;
        wr_en       = 1'b0;
        wr_idx      = r_count[IDX_W-1:0];
        wr_data     = {1'b0, r_id};

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    case (t_action'(i_action)) inside
                        ACT_ADD, ACT_QUERY: begin
                            n_id       = i_element_id;
                            n_is_query = (i_action == ACT_QUERY);
                            n_rows     = RC_W'(rows_sum >> LANE_W);
                            n_rd_row   = '0;
                            n_found    = 1'b0;
                            n_state    = S_SCAN;
                        end
                        ACT_FINISH: begin
                            n_out_valid = 1'b1;
                            n_out_count = r_matches;
                            n_out_ovf   = r_ovf;
                            n_count     = '0;
                            n_matches   = '0;
                            n_ovf       = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (rd_issue) begin
                    n_rd_row = r_rd_row + RC_W'(1);
                end
                n_cmp_vld = rd_issue;
                n_cmp_row = r_rd_row[ROW_W-1:0];
                if (|lane_hit) begin
                    n_found    = 1'b1;
                    n_hit_mark = hit_mark;
                    n_hit_idx  = IDX_W'({r_cmp_row, hit_lane});
                end
                // scan drained: apply the request
                if (!rd_issue && !r_cmp_vld) begin
                    n_state = S_IDLE;
                    if (r_is_query) begin
                        if (r_found && !r_hit_mark) begin
                            wr_en   = 1'b1;
                            wr_idx  = r_hit_idx;
                            wr_data = {1'b1, r_id};
                            if (r_matches < COUNT_MAX) begin
                                n_matches = r_matches + COUNT_W'(1);
                            end
                        end
                    end else if (!r_found) begin
                        if (r_count < CNT_W'(SET_CAPACITY)) begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmp_vld   <= 1'b0;
            r_count     <= '0;
            r_matches   <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_vld   <= n_cmp_vld;
            r_count     <= n_count;
            r_matches   <= n_matches;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id        <= n_id;
        r_is_query  <= n_is_query;
        r_rows      <= n_rows;
        r_rd_row    <= n_rd_row;
        r_cmp_row   <= n_cmp_row;
        r_found     <= n_found;
        r_hit_mark  <= n_hit_mark;
        r_hit_idx   <= n_hit_idx;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_out_valid    = r_out_valid;
    assign o_common_count = r_out_count;
    assign o_overflow     = r_out_ovf;

endmodule

FILE: rtl/sic_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sic_checker
    import sic_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [1:0]         i_action,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [COUNT_W-1:0] o_common_count,
    input logic               o_overflow
);

    logic acc_scan;
    logic acc_finish;

    assign acc_scan   = i_in_valid && !o_in_stall
                     && ((i_action == ACT_ADD) || (i_action == ACT_QUERY));
    assign acc_finish = i_in_valid && !o_in_stall && (i_action == ACT_FINISH);

    // add/query requests keep the block busy for at least the next cycle
    `SIC_ASSERT_NEXT(a_busy_after_scan, acc_scan, o_in_stall)

    // an accepted finish always shows a result next cycle
    `SIC_ASSERT_NEXT(a_finish_result, acc_finish, o_out_valid)

    // a taken result with no new finish leaves the output empty
    `SIC_ASSERT_NEXT(a_result_once, o_out_valid && !i_out_stall && !acc_finish, !o_out_valid)

    `SIC_ASSERT_NEXT(a_result_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_common_count) && $stable(o_overflow))

endmodule

bind set_intersection_counter_unit sic_checker u_sic_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_action       (i_action),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_common_count (o_common_count),
    .o_overflow     (o_overflow)
);

FILE: verif/set_intersection_counter_unit_tb.sv
`timescale 1ns / 1ps

module set_intersection_counter_unit_tb;
    import sic_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         SETTLE_CYC  = 24;    // longer than a worst-case scan
    localparam int         RESET_CYC   = 9;
    localparam int         PHASE_ITEMS = 350;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } t_tally;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_in_valid   = 1'b0;
    logic [1:0]         i_action     = ACT_ADD;
    logic [ID_W-1:0]    i_element_id = '0;
    logic               i_out_stall  = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [COUNT_W-1:0] o_common_count;
    logic               o_overflow;

    // shadow of the block's set state
    logic [ID_W-1:0]    shadow_ids [SET_CAPACITY];
    bit                 shadow_hit [SET_CAPACITY];
    int unsigned        shadow_n       = 0;
    logic [COUNT_W-1:0] shadow_matches = '0;
    bit                 shadow_ovf     = 1'b0;

    t_tally      expected_tallies[$];
    int unsigned send_idle_pct   = 0;
    int unsigned out_stall_pct   = 0;
    int unsigned error_count     = 0;
    int unsigned requests_sent   = 0;
    int unsigned tallies_checked = 0;
    int unsigned overflow_sets   = 0;

    set_intersection_counter_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_element_id   (i_element_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_common_count (o_common_count),
        .o_overflow     (o_overflow)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    function automatic int find_shadow(input logic [ID_W-1:0] id);
        for (int k = 0; k < shadow_n; k++) begin
            if (shadow_ids[k] == id) return k;
        end
        return -1;
    endfunction

    function automatic void track_request(input logic [1:0] act, input logic [ID_W-1:0] id);
        int hit;
        t_tally tally;
        case (act)
            ACT_ADD: begin
                if (find_shadow(id) < 0) begin
                    if (shadow_n < SET_CAPACITY) begin
                        shadow_ids[shadow_n] = id;
                        shadow_hit[shadow_n] = 1'b0;
                        shadow_n++;
                    end else begin
                        shadow_ovf = 1'b1;
                    end
                end
            end
            ACT_QUERY: begin
                hit = find_shadow(id);
                if (hit >= 0 && !shadow_hit[hit]) begin
                    shadow_hit[hit] = 1'b1;
                    if (shadow_matches != COUNT_MAX) shadow_matches++;
                end
            end
            ACT_FINISH: begin
                tally.count    = shadow_matches;
                tally.overflow = shadow_ovf;
                expected_tallies = {expected_tallies, tally};
                for (int k = 0; k < SET_CAPACITY; k++) shadow_hit[k] = 1'b0;
                shadow_n       = 0;
                shadow_matches = '0;
                shadow_ovf     = 1'b0;
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : check_tally
        t_tally want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_tallies.size() == 0) begin
                $display("%0t: unexpected result count %0d overflow %0d",
                         $time, o_common_count, o_overflow);
                error_count++;
            end else begin
                want = expected_tallies.pop_front();
                tallies_checked++;
                if (want.overflow) overflow_sets++;
                if (o_common_count !== want.count) begin
                    $display("%0t: common_count expected %0d actual %0d",
                             $time, want.count, o_common_count);
                    error_count++;
                end
                if (o_overflow !== want.overflow) begin
                    $display("%0t: overflow expected %0d actual %0d",
                             $time, want.overflow, o_overflow);
                    error_count++;
                end
            end
        end
    end

    task automatic send_request(input logic [1:0] act, input logic [ID_W-1:0] id);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_element_id <= id;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        track_request(act, id);
        if (act != ACT_UNUSED) requests_sent++;
    endtask

    // hold off new requests until every pending result is back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tallies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_request(ACT_FINISH, 32'h0);               // empty set
        send_request(ACT_QUERY, 32'd5);                // query with nothing stored
        send_request(ACT_ADD, 32'h0000_0000);
        send_request(ACT_ADD, 32'hFFFF_FFFF);
        send_request(ACT_ADD, 32'h0000_0000);          // duplicate add
        send_request(ACT_ADD, 32'd12345);
        send_request(ACT_QUERY, 32'h0000_0000);
        send_request(ACT_QUERY, 32'h0000_0000);        // repeat counts once
        send_request(ACT_QUERY, 32'hFFFF_FFFF);
        send_request(ACT_QUERY, 32'd777);              // miss
        send_request(ACT_UNUSED, 32'hFFFF_FFFF);       // ignored code
        send_request(ACT_QUERY, 32'd12345);
        send_request(ACT_FINISH, 32'hFFFF_FFFF);
        send_request(ACT_ADD, 32'hA5A5_A5A5);
        send_request(ACT_QUERY, 32'hA5A5_A5A5);
        send_request(ACT_ADD, 32'h5A5A_5A5A);          // add after a query
        send_request(ACT_QUERY, 32'h5A5A_5A5A);
        send_request(ACT_QUERY, 32'hA5A5_A5A5);
        send_request(ACT_FINISH, 32'h0);
        send_request(ACT_FINISH, 32'h0);               // back-to-back finish
        drain_results();
    endtask

    task automatic test_capacity();
        logic [ID_W-1:0] base;
        base = $urandom();
        for (int k = 0; k < SET_CAPACITY; k++) send_request(ACT_ADD, base + k);
        send_request(ACT_ADD, base + 1000);            // full: dropped, flags overflow
        send_request(ACT_ADD, base + 5);               // full but duplicate
        send_request(ACT_QUERY, base + 1000);
        for (int k = SET_CAPACITY - 1; k >= 0; k--) send_request(ACT_QUERY, base + k);
        send_request(ACT_QUERY, base + 7);
        send_request(ACT_FINISH, base);
        send_request(ACT_FINISH, base);                // flag must be cleared
        base = $urandom();
        for (int k = 0; k < SET_CAPACITY; k++) send_request(ACT_ADD, base - k);
        send_request(ACT_ADD, base - 3);               // duplicate only, no overflow
        send_request(ACT_QUERY, base);
        send_request(ACT_QUERY, base - 255);
        send_request(ACT_FINISH, base);
        drain_results();
    endtask

    task automatic send_random_set();
        logic [ID_W-1:0] base;
        int unsigned     span;
        int unsigned     n_add;
        int unsigned     n_query;
        bit              in_order;
        base = $urandom();
        case ($urandom_range(0, 3))
            0:       span = 3;
            1:       span = 15;
            2:       span = 63;
            default: span = 1023;
        endcase
        if ($urandom_range(0, 14) == 0) begin
            n_add = $urandom_range(240, 320);
            span  = 1023;
        end else begin
            n_add = $urandom_range(0, 24);
        end
        n_query  = $urandom_range(0, 24);
        in_order = ($urandom_range(0, 4) != 0);
        while (n_add + n_query > 0) begin
            if ($urandom_range(0, 19) == 0) send_request(ACT_UNUSED, $urandom());
            if (n_add > 0 && (in_order || n_query == 0 || $urandom_range(0, 1))) begin
                send_request(ACT_ADD, base ^ $urandom_range(0, span));
                n_add--;
            end else begin
                send_request(ACT_QUERY, base ^ $urandom_range(0, span));
                n_query--;
            end
        end
        send_request(ACT_FINISH, $urandom());
    endtask

    task automatic test_random(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned start;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        start = requests_sent;
        while (requests_sent - start < PHASE_ITEMS) send_random_set();
        drain_results();
    endtask

    initial begin
        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 31;
        out_stall_pct = 87;
        test_directed();
        test_capacity();
        test_random(31, 87);
        test_random(87, 31);
        test_random(0, 0);
        $display("Run covered %0d requests and %0d checked results, %0d with overflow set.",
                 requests_sent, tallies_checked, overflow_sets);
        $display("Included capacity fill, duplicate adds and queries, and ignored action codes.");
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout with %0d results outstanding", expected_tallies.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
